// File: rtl/core/clkpr_pkg.sv
// shared types and constants for the clock page replacement unit
`default_nettype none

package clkpr_pkg;

    localparam int FRAME_W = 8;
    localparam int CFG_W   = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic REQ_REF   = 1'b0;
    localparam logic REQ_EVICT = 1'b1;

    // one resident-set slot as held in the entry ram
    typedef struct packed {
        logic               use_bit;
        logic [FRAME_W-1:0] frame;
    } clkpr_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic search_step;
        logic set_use;
        logic evict_rd;
        logic rotate;
        logic evict_final;
        logic append;
        logic load_out;
    } clkpr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic ref_req;
        logic match;
        logic search_miss;
        logic full;
        logic last_pick;
    } clkpr_status_t;

endpackage

`default_nettype wire

// File: rtl/core/clkpr_dp.sv
// datapath: entry ram, clock hand, resident count, capacity register and result registers
`default_nettype none

module clkpr_dp #(
    parameter int MAX_FRAMES = 256
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_valid,
    input  wire [clkpr_pkg::CFG_W-1:0]      cfg_data,
    input  wire                             s_req_type,
    input  wire [clkpr_pkg::FRAME_W-1:0]    s_frame_number,
    input  clkpr_pkg::clkpr_cmd_t           cmd,
    output clkpr_pkg::clkpr_status_t        status,
    output logic                            m_hit,
    output logic                            m_evicted,
    output logic [clkpr_pkg::FRAME_W-1:0]   m_victim_frame,
    output logic                            m_empty_error
);
    import clkpr_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    clkpr_entry_t           mem [MAX_FRAMES];

    logic [CFG_W-1:0]       frames_in_use_reg;
    logic [IDX_W-1:0]       hand_reg, hand_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic                   req_reg;
    logic [FRAME_W-1:0]     frame_reg;
    clkpr_entry_t           rd_q_reg;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_slot_reg;
    logic                   res_hit_reg, res_evicted_reg, res_err_reg;
    logic [FRAME_W-1:0]     res_victim_reg;

    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    clkpr_entry_t           wr_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       hand_inc;
    logic [IDX_W-1:0]       tail_slot;
    logic [CMP_W-1:0]       cap_eff;

    // slot of the entry at an offset from the hand, offset at most MAX_FRAMES
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_FRAMES)) begin
            sum = sum - SUM_W'(MAX_FRAMES);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign hand_inc  = (hand_reg == IDX_W'(MAX_FRAMES - 1)) ? '0 : hand_reg + 1'b1;
    assign tail_slot = slot_of(hand_reg, count_reg);

    // zero capacity acts as one, large values saturate
    always_comb begin
        if (frames_in_use_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(frames_in_use_reg) > CMP_W'(MAX_FRAMES)) begin
            cap_eff = CMP_W'(MAX_FRAMES);
        end else begin
            cap_eff = CMP_W'(frames_in_use_reg);
        end
    end

    always_comb begin
        rd_vld_next = cmd.search_step && (k_reg < count_reg);
        k_next      = k_reg;
        rd_addr     = hand_reg;
        if (cmd.load_in) begin
            k_next = '0;
        end else if (rd_vld_next) begin
            k_next  = k_reg + 1'b1;
            rd_addr = slot_of(hand_reg, k_reg);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = tail_slot;
        wr_data = '{use_bit: 1'b0, frame: frame_reg};
        if (cmd.set_use) begin
            wr_en   = 1'b1;
            wr_addr = rd_slot_reg;
            wr_data = '{use_bit: 1'b1, frame: frame_reg};
        end else if (cmd.rotate) begin
            // second chance: bit cleared, entry goes to the newest position
            wr_en   = 1'b1;
            wr_data = '{use_bit: 1'b0, frame: rd_q_reg.frame};
        end else if (cmd.append) begin
            wr_en   = 1'b1;
        end
    end

    always_comb begin
        hand_next  = hand_reg;
        count_next = count_reg;
        if (cmd.rotate) begin
            hand_next = hand_inc;
        end else if (cmd.evict_final) begin
            count_next = count_reg - 1'b1;
            hand_next  = (count_reg == CNT_W'(1)) ? '0 : hand_inc;
        end else if (cmd.append) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read port loads for a search step or an eviction read
        if (rd_vld_next || cmd.evict_rd) begin
            rd_q_reg    <= mem[rd_addr];
            rd_slot_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= CFG_RESET;
            hand_reg          <= '0;
            count_reg         <= '0;
            k_reg             <= '0;
            rd_vld_reg        <= 1'b0;
            res_hit_reg       <= 1'b0;
            res_evicted_reg   <= 1'b0;
            res_err_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                frames_in_use_reg <= cfg_data;
            end
            hand_reg   <= hand_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            rd_vld_reg <= rd_vld_next;
            if (cmd.load_in) begin
                res_hit_reg     <= 1'b0;
                res_evicted_reg <= 1'b0;
                res_err_reg     <= (s_req_type == REQ_EVICT) && (count_reg == '0);
            end else begin
                if (cmd.set_use) begin
                    res_hit_reg <= 1'b1;
                end
                if (cmd.evict_final) begin
                    res_evicted_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg        <= s_req_type;
            frame_reg      <= s_frame_number;
            res_victim_reg <= '0;
        end else if (cmd.evict_final) begin
            res_victim_reg <= rd_q_reg.frame;
        end
        if (cmd.load_out) begin
            m_hit          <= res_hit_reg;
            m_evicted      <= res_evicted_reg;
            m_victim_frame <= res_victim_reg;
            m_empty_error  <= res_err_reg;
        end
    end

    assign status.empty       = (count_reg == '0);
    assign status.ref_req     = (req_reg == REQ_REF);
    assign status.match       = rd_vld_reg && (rd_q_reg.frame == frame_reg);
    assign status.search_miss = !rd_vld_reg && (k_reg == count_reg);
    assign status.full        = (CMP_W'(count_reg) >= cap_eff) && (count_reg != '0);
    assign status.last_pick   = !rd_q_reg.use_bit || (count_reg == CNT_W'(1));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("resident count above frame slots");

    a_hand_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hand_reg <= IDX_W'(MAX_FRAMES - 1))
        else $error("clock hand out of range");

    a_empty_hand: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> hand_reg == '0)
        else $error("empty set with hand off zero");

    a_evict_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict_final |=> count_reg == $past(count_reg) - 1'b1)
        else $error("eviction did not shrink the set by one");

    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_hit_reg |-> !res_evicted_reg && !res_err_reg)
        else $error("hit reported together with eviction or error");

endmodule

`default_nettype wire

// File: rtl/core/clkpr_ctrl.sv
// controller: sequences search, eviction scan, append and result handoff
`default_nettype none

module clkpr_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    input  wire                         s_req_type,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire                         m_ready,
    input  clkpr_pkg::clkpr_status_t    status,
    output clkpr_pkg::clkpr_cmd_t       cmd
);
    import clkpr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_APPEND,
        ST_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (s_req_type == REQ_EVICT) begin
                        state_next = status.empty ? ST_REPLY : ST_EVICT_RD;
                    end else begin
                        state_next = status.empty ? ST_APPEND : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (status.match) begin
                    cmd.set_use = 1'b1;
                    state_next  = ST_REPLY;
                end else if (status.search_miss) begin
                    state_next = status.full ? ST_EVICT_RD : ST_APPEND;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_EVICT_RD: begin
                cmd.evict_rd = 1'b1;
                state_next   = ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                if (status.last_pick) begin
                    cmd.evict_final = 1'b1;
                    state_next      = status.ref_req ? ST_APPEND : ST_REPLY;
                end else begin
                    cmd.rotate = 1'b1;
                    state_next = ST_EVICT_RD;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_REPLY;
            end
            ST_REPLY: begin
                // result register frees up once the waiting item is taken
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_valid_reg || m_ready)
        else $error("result overwritten before it was taken");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted item not processed");

    a_evict_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EVICT_CHK |-> $past(state_reg) == ST_EVICT_RD)
        else $error("eviction check without a fresh read");

endmodule

`default_nettype wire

// File: rtl/core/clock_page_replacement_unit.sv
// top level of the second-chance clock page replacement unit
`default_nettype none

// Second-chance (clock) replacement over up to MAX_FRAMES resident frames,
// one item at a time. A page reference searches the resident set oldest
// first, one slot per cycle through the registered read port of the entry
// ram. Any eviction scan reads and then checks every entry it visits, the
// victim included. The next item is accepted as soon as the result sits
// in the output register, even if it has not been taken yet; a finished
// item waits while the previous result is still held there.
// frames_in_use is written through cfg_valid/cfg_data, which always accepts;
// write it only while the unit is idle. No clearing pass follows reset.
module clock_page_replacement_unit #(
    parameter int MAX_FRAMES = 256
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [clkpr_pkg::CFG_W-1:0]      cfg_data,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_req_type,
    input  wire [clkpr_pkg::FRAME_W-1:0]    s_frame_number,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_hit,
    output logic                            m_evicted,
    output logic [clkpr_pkg::FRAME_W-1:0]   m_victim_frame,
    output logic                            m_empty_error
);
    import clkpr_pkg::*;

    clkpr_cmd_t    cmd;
    clkpr_status_t status;

    assign cfg_ready = 1'b1;

    clkpr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    clkpr_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_req_type     (s_req_type),
        .s_frame_number (s_frame_number),
        .cmd            (cmd),
        .status         (status),
        .m_hit          (m_hit),
        .m_evicted      (m_evicted),
        .m_victim_frame (m_victim_frame),
        .m_empty_error  (m_empty_error)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for the clock page replacement unit
module tb;
    import clkpr_pkg::*;

    localparam int SLOTS       = 256;
    localparam int QUIET_LIMIT = 6000;
    localparam int HOLDOFF     = 300;
    localparam int PHASES      = 10;

    typedef struct packed {
        logic               hit;
        logic               evicted;
        logic [FRAME_W-1:0] victim;
        logic               empty_err;
    } page_result_t;

    // resident-set predictor plus the queue of results still owed by the unit
    class clock_scoreboard;
        logic [FRAME_W-1:0] slot_frame [SLOTS];
        bit                 slot_use   [SLOTS];
        bit                 slot_valid [SLOTS];
        int unsigned        hand;
        int unsigned        resident;
        logic [CFG_W-1:0]   capacity_reg;
        page_result_t       owed_q [$];
        int unsigned        n_items, n_cfg, n_checked, n_errors;
        int unsigned        n_hits, n_evictions, n_empty;

        function new();
            hand         = 0;
            resident     = 0;
            capacity_reg = CFG_RESET;
            foreach (slot_use[i]) begin
                slot_use[i]   = 1'b0;
                slot_valid[i] = 1'b0;
                slot_frame[i] = '0;
            end
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity_reg = value;
            n_cfg++;
        endfunction

        function int unsigned usable_slots();
            int unsigned c;
            c = 32'(capacity_reg);
            if (c == 0) c = 1;
            if (c > SLOTS) c = SLOTS;
            return c;
        endfunction

        // second-chance scan from the oldest entry, removes and returns the victim
        function logic [FRAME_W-1:0] take_victim();
            int unsigned        h, t, g;
            logic [FRAME_W-1:0] f, v;
            for (g = 0; g <= resident; g++) begin
                h = hand % SLOTS;
                if (!slot_use[h] || resident == 1) break;
                f             = slot_frame[h];
                slot_valid[h] = 1'b0;
                slot_use[h]   = 1'b0;
                hand          = (h + 1) % SLOTS;
                t             = (hand + resident - 1) % SLOTS;
                slot_frame[t] = f;
                slot_use[t]   = 1'b0;
                slot_valid[t] = 1'b1;
            end
            h             = hand % SLOTS;
            v             = slot_valid[h] ? slot_frame[h] : '0;
            slot_valid[h] = 1'b0;
            slot_use[h]   = 1'b0;
            hand          = (h + 1) % SLOTS;
            resident--;
            if (resident == 0) hand = 0;
            return v;
        endfunction

        function void note_request(logic req, logic [FRAME_W-1:0] frame);
            page_result_t r;
            int unsigned  k, s, t;
            r = '0;
            if (req == REQ_EVICT) begin
                if (resident == 0) begin
                    r.empty_err = 1'b1;
                end else begin
                    r.victim  = take_victim();
                    r.evicted = 1'b1;
                end
            end else begin
                for (k = 0; k < resident; k++) begin
                    s = (hand + k) % SLOTS;
                    if (slot_valid[s] && slot_frame[s] == frame) begin
                        slot_use[s] = 1'b1;
                        r.hit       = 1'b1;
                        break;
                    end
                end
                if (!r.hit) begin
                    // a full set (or one over a lowered capacity) gives up one victim
                    if (resident >= usable_slots() && resident > 0) begin
                        r.victim  = take_victim();
                        r.evicted = 1'b1;
                    end
                    t             = (hand + resident) % SLOTS;
                    slot_frame[t] = frame;
                    slot_use[t]   = 1'b0;
                    slot_valid[t] = 1'b1;
                    resident++;
                end
            end
            n_items++;
            if (r.hit) n_hits++;
            if (r.evicted) n_evictions++;
            if (r.empty_err) n_empty++;
            owed_q.push_back(r);
        endfunction

        function void check_result(page_result_t got);
            page_result_t exp_r;
            if (owed_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch: unexpected result hit=%0b evicted=%0b victim=%0d err=%0b",
                             got.hit, got.evicted, got.victim, got.empty_err);
                return;
            end
            exp_r = owed_q.pop_front();
            n_checked++;
            if (got.hit !== exp_r.hit || got.evicted !== exp_r.evicted ||
                got.victim !== exp_r.victim || got.empty_err !== exp_r.empty_err) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch on result %0d: expected hit=%0b evicted=%0b victim=%0d err=%0b",
                             n_checked, exp_r.hit, exp_r.evicted, exp_r.victim,
                             exp_r.empty_err);
                    $display("    got hit=%0b evicted=%0b victim=%0d err=%0b",
                             got.hit, got.evicted, got.victim, got.empty_err);
                end
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data       = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_req_type     = REQ_REF;
    logic [FRAME_W-1:0] s_frame_number = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_hit;
    logic               m_evicted;
    logic [FRAME_W-1:0] m_victim_frame;
    logic               m_empty_error;

    clock_scoreboard sb = new();

    int unsigned stall_pct    = 0;
    int unsigned idle_pct     = 0;
    int unsigned holdoff_req  = 0;
    int unsigned holdoff_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    // per-phase capacity, item count, frame span, evict share; span 0 means sequential frames
    int unsigned phase_cap   [PHASES] = '{4, 1, 8, 2, 16, 0, 511, 3, 256, 32};
    int unsigned phase_items [PHASES] = '{140, 100, 140, 100, 140, 60, 400, 100, 80, 140};
    int unsigned phase_span  [PHASES] = '{6, 3, 12, 4, 24, 2, 0, 5, 256, 48};
    int unsigned phase_evict [PHASES] = '{10, 15, 10, 15, 8, 20, 5, 40, 10, 10};

    clock_page_replacement_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_evicted      (m_evicted),
        .m_victim_frame (m_victim_frame),
        .m_empty_error  (m_empty_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            hold_left    <= HOLDOFF;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_hit, m_evicted, m_victim_frame, m_empty_error});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic req, input logic [FRAME_W-1:0] frame);
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_frame_number <= frame;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, frame);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = 0;
        while ($urandom_range(0, 99) < idle_pct && n < 40) n++;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained(input int unsigned tail);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_drained(16);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_capacity(value);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic               req;
        logic [FRAME_W-1:0] frame, base, seq_ptr;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty set, append, hit, rotation of a used entry, back to empty
        send_item(REQ_EVICT, 8'hFF);
        send_item(REQ_REF, 8'd0);
        send_item(REQ_REF, 8'd255);
        send_item(REQ_REF, 8'd0);
        send_item(REQ_EVICT, 8'd0);
        send_item(REQ_EVICT, 8'hAA);
        // lone entry with its use bit set
        send_item(REQ_REF, 8'd5);
        send_item(REQ_REF, 8'd5);
        send_item(REQ_EVICT, 8'd0);
        s_valid <= 1'b0;

        // every use bit set when the set is full
        write_capacity(9'd3);
        send_item(REQ_REF, 8'd1);
        send_item(REQ_REF, 8'd2);
        send_item(REQ_REF, 8'd3);
        send_item(REQ_REF, 8'd1);
        send_item(REQ_REF, 8'd2);
        send_item(REQ_REF, 8'd3);
        send_item(REQ_REF, 8'd4);
        s_valid <= 1'b0;

        // zero capacity acts as one; set above capacity shrinks only by evicts
        write_capacity(9'd0);
        send_item(REQ_REF, 8'd7);
        send_item(REQ_EVICT, 8'h55);
        send_item(REQ_EVICT, 8'd0);
        send_item(REQ_EVICT, 8'd0);
        send_item(REQ_EVICT, 8'd0);
        send_item(REQ_REF, 8'd9);
        send_item(REQ_REF, 8'd10);
        send_item(REQ_REF, 8'h80);
        send_item(REQ_EVICT, 8'd0);
        s_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p][CFG_W-1:0]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            base    = FRAME_W'($urandom);
            seq_ptr = FRAME_W'($urandom);
            for (int i = 0; i < phase_items[p]; i++) begin
                sender_gap();
                req = ($urandom_range(0, 99) < phase_evict[p]) ? REQ_EVICT : REQ_REF;
                if (phase_span[p] == 0) begin
                    // mostly fresh frames to fill the set, some recent ones to set use bits
                    if ($urandom_range(0, 99) < 85) begin
                        frame   = seq_ptr;
                        seq_ptr = seq_ptr + 8'd1;
                    end else begin
                        frame = seq_ptr - 8'd1 - FRAME_W'($urandom_range(0, 63));
                    end
                end else if ($urandom_range(0, 99) < 80) begin
                    frame = base + FRAME_W'($urandom_range(0, phase_span[p] - 1));
                end else begin
                    frame = FRAME_W'($urandom);
                end
                if (p == 2 && i == 40)
                    holdoff_req++;
                if (p == 4 && i == 70) begin
                    s_valid <= 1'b0;
                    wait_drained(8);
                end
                send_item(req, frame);
            end
            s_valid <= 1'b0;
        end

        wait_drained(40);
        $display("ran %0d items, %0d capacity writes: %0d hits, %0d evictions, %0d empty",
                 sb.n_items, sb.n_cfg, sb.n_hits, sb.n_evictions, sb.n_empty);
        $display("%0d results checked, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
